FILE: rtl/gdw_pkg.sv
// gdw_pkg: shared constants, item structs and the controller/datapath
// command and status types of the graph depth-first walker.
// No dependencies.
package gdw_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_DEGREE   = 8;
	localparam int MAX_RESULTS  = 64;

	localparam int VW   = $clog2(MAX_VERTICES);        // vertex id width
	localparam int DW   = $clog2(MAX_DEGREE);          // slot index width
	localparam int DCW  = DW + 1;                      // degree count width
	localparam int SD   = MAX_VERTICES * MAX_DEGREE;   // store and stack depth
	localparam int SAW  = VW + DW;                     // store/stack address width
	localparam int SPW  = SAW + 1;                     // stack pointer width
	localparam int CW   = $clog2(MAX_RESULTS + 1);     // visit count width
	localparam int NVW  = 7;                           // num_vertices register width

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_VISIT = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic          operation;
		logic [VW-1:0] vertex_a;
		logic [VW-1:0] vertex_b;
	} in_item_t;

	typedef struct packed {
		logic          kind;
		logic [VW-1:0] vertex;
		logic          last;
		logic [1:0]    status;
	} out_item_t;

	typedef struct packed {
		logic load_in;
		logic ins_rd;
		logic ins_w1;
		logic ins_w2;
		logic ack;
		logic srch_err;
		logic srch_init;
		logic pop;
		logic visit;
		logic nb_start;
		logic nb_step;
		logic flush;
	} gdw_cmd_t;

	typedef struct packed {
		logic start_ok;
		logic ins_ok;
		logic sp_zero;
		logic cnt_full;
		logic pop_ok;
		logic pend_vld;
		logic out_free;
		logic nb_done;
	} gdw_st_t;

endpackage

FILE: rtl/gdw_ctrl.sv
// gdw_ctrl: sequencer for insert and depth-first search items.
// Depends on gdw_pkg (command and status structs, operation codes).
module gdw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_op,
	output logic              req_ready,
	input  gdw_pkg::gdw_st_t  st,
	output gdw_pkg::gdw_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_INS_W1,
		S_INS_W2,
		S_INS_ACK,
		S_SRCH_CHK,
		S_SRCH_ERR,
		S_POP,
		S_TEST,
		S_DEG,
		S_NB,
		S_FIN
	} state_t;

	state_t state_q, state_nxt;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_nxt   = (req_op == gdw_pkg::OP_SEARCH) ? S_SRCH_CHK : S_INS_RD;
				end
			end
			S_INS_RD: begin
				cmd.ins_rd = 1'b1;
				state_nxt  = S_INS_CHK;
			end
			S_INS_CHK: begin
				state_nxt = st.ins_ok ? S_INS_W1 : S_INS_ACK;
			end
			S_INS_W1: begin
				cmd.ins_w1 = 1'b1;
				state_nxt  = S_INS_W2;
			end
			S_INS_W2: begin
				cmd.ins_w2 = 1'b1;
				state_nxt  = S_INS_ACK;
			end
			S_INS_ACK: begin
				if (st.out_free) begin
					cmd.ack   = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_SRCH_CHK: begin
				if (st.start_ok) begin
					cmd.srch_init = 1'b1;
					state_nxt     = S_POP;
				end else begin
					state_nxt = S_SRCH_ERR;
				end
			end
			S_SRCH_ERR: begin
				if (st.out_free) begin
					cmd.srch_err = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			S_POP: begin
				if (st.sp_zero || st.cnt_full) begin
					state_nxt = S_FIN;
				end else begin
					cmd.pop   = 1'b1;
					state_nxt = S_TEST;
				end
			end
			S_TEST: begin
				if (!st.pop_ok) begin
					state_nxt = S_POP;
				end else if (!st.pend_vld || st.out_free) begin
					cmd.visit = 1'b1;
					state_nxt = S_DEG;
				end
			end
			S_DEG: begin
				cmd.nb_start = 1'b1;
				state_nxt    = S_NB;
			end
			S_NB: begin
				if (st.nb_done) begin
					state_nxt = S_POP;
				end else begin
					cmd.nb_step = 1'b1;
				end
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: rtl/gdw_dp.sv
// gdw_dp: graph storage, walk stack, visited map and result register.
// Depends on gdw_pkg; driven by gdw_ctrl through gdw_cmd_t / gdw_st_t.
module gdw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gdw_pkg::NVW-1:0]       cfg_wdata,
	input  gdw_pkg::in_item_t             req,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output gdw_pkg::out_item_t            rsp,
	input  gdw_pkg::gdw_cmd_t             cmd,
	output gdw_pkg::gdw_st_t              st
);

	localparam int VW  = gdw_pkg::VW;
	localparam int DW  = gdw_pkg::DW;
	localparam int DCW = gdw_pkg::DCW;
	localparam int SAW = gdw_pkg::SAW;
	localparam int SPW = gdw_pkg::SPW;
	localparam int CW  = gdw_pkg::CW;
	localparam int NVW = gdw_pkg::NVW;
	localparam int NV  = gdw_pkg::MAX_VERTICES;
	localparam int SD  = gdw_pkg::SD;

	// config and latched item
	logic [NVW-1:0] nv_q;
	logic [NVW-1:0] nv_eff;
	logic           op_q;
	logic [VW-1:0]  a_q, b_q;

	// memories
	logic [DCW-1:0] deg_mem [NV];
	logic [NV-1:0]  deg_vld_q;
	logic [VW-1:0]  nb_mem  [SD];
	logic [VW-1:0]  stk_mem [SD];

	logic [DCW-1:0] deg_a_q, deg_b_q;
	logic [VW-1:0]  nb_rd_q;
	logic [VW-1:0]  stk_rd_q;

	// walk state
	logic [SPW-1:0] sp_q;
	logic [CW-1:0]  cnt_q;
	logic [NV-1:0]  visited_q;
	logic [VW-1:0]  u_q;
	logic [DCW-1:0] d_q, i_q;
	logic           nb_rd_vld_q;
	logic [VW-1:0]  pend_q;
	logic           pend_vld_q;
	logic           out_vld_q;
	gdw_pkg::out_item_t out_q;

	// combinational
	logic           out_free;
	logic           out_load;
	gdw_pkg::out_item_t out_nxt;
	logic [1:0]     ins_st;
	logic [DCW-1:0] db2;
	logic           deg_we;
	logic [VW-1:0]  deg_wa;
	logic [DCW-1:0] deg_wd;
	logic           deg_re;
	logic [VW-1:0]  deg_ra;
	logic           nb_we;
	logic [SAW-1:0] nb_wa;
	logic [VW-1:0]  nb_wd;
	logic           nb_re;
	logic           stk_we;
	logic [SAW-1:0] stk_wa;
	logic [VW-1:0]  stk_wd;
	logic [SPW-1:0] sp_dec;
	logic           push;

	assign nv_eff = (nv_q > NVW'(NV)) ? NVW'(NV) : nv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= NVW'(NV);
		end else if (cfg_we) begin
			nv_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= req.operation;
			a_q  <= req.vertex_a;
			b_q  <= req.vertex_b;
		end
	end

	// insert status from registered degree reads
	assign db2 = (a_q == b_q) ? deg_a_q + DCW'(1) : deg_b_q;

	always_comb begin
		if (({1'b0, a_q} >= nv_eff) || ({1'b0, b_q} >= nv_eff)) begin
			ins_st = gdw_pkg::ST_RANGE;
		end else if (a_q == b_q) begin
			ins_st = (({1'b0, deg_a_q} + (DCW+1)'(2)) > (DCW+1)'(gdw_pkg::MAX_DEGREE))
				? gdw_pkg::ST_FULL : gdw_pkg::ST_OK;
		end else if ((deg_a_q >= DCW'(gdw_pkg::MAX_DEGREE)) ||
			(deg_b_q >= DCW'(gdw_pkg::MAX_DEGREE))) begin
			ins_st = gdw_pkg::ST_FULL;
		end else begin
			ins_st = gdw_pkg::ST_OK;
		end
	end

	// degree store: one write port, two registered reads, valid bit per entry
	assign deg_we = cmd.ins_w1 | cmd.ins_w2;
	assign deg_wa = cmd.ins_w1 ? a_q : b_q;
	assign deg_wd = cmd.ins_w1 ? deg_a_q + DCW'(1) : db2 + DCW'(1);
	assign deg_re = cmd.ins_rd | cmd.visit;
	assign deg_ra = cmd.visit ? stk_rd_q : a_q;

	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_wa] <= deg_wd;
		end
		if (deg_re) begin
			deg_a_q <= deg_vld_q[deg_ra] ? deg_mem[deg_ra] : '0;
			deg_b_q <= deg_vld_q[b_q]    ? deg_mem[b_q]    : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q <= '0;
		end else if (deg_we) begin
			deg_vld_q[deg_wa] <= 1'b1;
		end
	end

	// neighbor store
	assign nb_we = cmd.ins_w1 | cmd.ins_w2;
	assign nb_wa = cmd.ins_w1 ? {a_q, deg_a_q[DW-1:0]} : {b_q, db2[DW-1:0]};
	assign nb_wd = cmd.ins_w1 ? b_q : a_q;
	assign nb_re = cmd.nb_step && (i_q < d_q);

	always_ff @(posedge clk) begin
		if (nb_we) begin
			nb_mem[nb_wa] <= nb_wd;
		end
		if (nb_re) begin
			nb_rd_q <= nb_mem[{u_q, i_q[DW-1:0]}];
		end
	end

	// walk stack
	assign sp_dec = sp_q - SPW'(1);
	assign push   = cmd.nb_step && nb_rd_vld_q && ({1'b0, nb_rd_q} < nv_eff) &&
		!visited_q[nb_rd_q] && (sp_q < SPW'(SD));
	assign stk_we = cmd.srch_init | push;
	assign stk_wa = cmd.srch_init ? '0 : sp_q[SAW-1:0];
	assign stk_wd = cmd.srch_init ? a_q : nb_rd_q;

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (cmd.pop) begin
			stk_rd_q <= stk_mem[sp_dec[SAW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.srch_init) begin
			sp_q <= SPW'(1);
		end else if (cmd.pop) begin
			sp_q <= sp_dec;
		end else if (push) begin
			sp_q <= sp_q + SPW'(1);
		end else if (cmd.flush) begin
			sp_q <= '0;
		end
	end

	// visit bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q   <= '0;
			cnt_q       <= '0;
			pend_vld_q  <= 1'b0;
			nb_rd_vld_q <= 1'b0;
		end else begin
			if (cmd.srch_init) begin
				visited_q  <= '0;
				cnt_q      <= '0;
				pend_vld_q <= 1'b0;
			end else if (cmd.visit) begin
				visited_q[stk_rd_q] <= 1'b1;
				cnt_q               <= cnt_q + CW'(1);
				pend_vld_q          <= 1'b1;
			end else if (cmd.flush) begin
				cnt_q      <= '0;
				pend_vld_q <= 1'b0;
			end
			if (cmd.nb_start) begin
				nb_rd_vld_q <= 1'b0;
			end else if (cmd.nb_step) begin
				nb_rd_vld_q <= nb_re;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.visit) begin
			u_q    <= stk_rd_q;
			pend_q <= stk_rd_q;
		end
		if (cmd.nb_start) begin
			d_q <= (deg_a_q > DCW'(gdw_pkg::MAX_DEGREE)) ?
				DCW'(gdw_pkg::MAX_DEGREE) : deg_a_q;
			i_q <= '0;
		end else if (nb_re) begin
			i_q <= i_q + DCW'(1);
		end
	end

	// result register
	assign out_free = !out_vld_q || rsp_ready;
	assign out_load = cmd.ack | cmd.srch_err | cmd.flush | (cmd.visit & pend_vld_q);

	always_comb begin
		out_nxt.kind   = gdw_pkg::KIND_VISIT;
		out_nxt.vertex = pend_q;
		out_nxt.last   = 1'b1;
		out_nxt.status = gdw_pkg::ST_OK;
		if (cmd.ack) begin
			out_nxt.kind   = gdw_pkg::KIND_ACK;
			out_nxt.vertex = '0;
			out_nxt.status = ins_st;
		end else if (cmd.srch_err) begin
			out_nxt.vertex = '0;
			out_nxt.status = gdw_pkg::ST_RANGE;
		end else if (cmd.visit) begin
			out_nxt.last = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_nxt;
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	// status to the sequencer
	assign st.start_ok = ({1'b0, a_q} < nv_eff) && (op_q == gdw_pkg::OP_SEARCH);
	assign st.ins_ok   = (ins_st == gdw_pkg::ST_OK);
	assign st.sp_zero  = (sp_q == '0);
	assign st.cnt_full = (cnt_q == CW'(gdw_pkg::MAX_RESULTS));
	assign st.pop_ok   = ({1'b0, stk_rd_q} < nv_eff) && !visited_q[stk_rd_q];
	assign st.pend_vld = pend_vld_q;
	assign st.out_free = out_free;
	assign st.nb_done  = (i_q >= d_q) && !nb_rd_vld_q;

endmodule

FILE: rtl/graph_dfs_walker_core.sv
// Timing: an insert reads both degree counts, checks them, writes both endpoints if accepted
// and then acknowledges; a search pops the walk stack, tests each popped vertex, and for each
// visited vertex reads its degree and scans its neighbor slots, serialised by the
// single read port of walk stack and neighbor store. One item at a time; stalls hold it.
// Reset: async active-low; clears the sequencer, degree valid bits, visited map,
// stack pointer and result valid; num_vertices returns to 64.
module graph_dfs_walker_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration: num_vertices
	input  logic                        cfg_we,
	input  logic [gdw_pkg::NVW-1:0]     cfg_wdata,
	// request channel
	input  logic                        req_valid,
	output logic                        req_ready,
	input  gdw_pkg::in_item_t           req,
	// result channel
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output gdw_pkg::out_item_t          rsp
);

	gdw_pkg::gdw_cmd_t cmd;
	gdw_pkg::gdw_st_t  st;

	// Sequencer: decodes the item and steps the walk; every storage
	// access is a command to the datapath.
	gdw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.operation),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: adjacency store (8 slots per vertex), degree counts,
	// walk stack, visited map. A visit is held back one step so the
	// final visit of a walk can be flagged last once the walk ends.
	gdw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.st        (st)
	);

	// No held-back visit may survive into the idle state.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !st.pend_vld)
		else $error("held visit left over while idle");

	// An accepted item blocks further requests on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while busy");

	// An acknowledgement is always the only and final item, vertex zero.
	a_ack_form: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.kind == gdw_pkg::KIND_ACK) |-> (rsp.last && rsp.vertex == '0))
		else $error("malformed acknowledgement");

	// Hitting the visit cap implies a visit is held for the final result.
	a_cap_pend: assert property (@(posedge clk) disable iff (!arst_n)
		st.cnt_full |-> st.pend_vld)
		else $error("visit cap reached with nothing held");

endmodule
